// ===== rtl/core/psd_pkg.sv =====
// psd_pkg: widths, register codes, configuration and queue item types, and the
// saturating add shared by the speed drive regulator. No dependencies.
package psd_pkg;

  localparam int CNT_W      = 16;
  localparam int ERR_W      = CNT_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int GAIN_W     = 40;
  localparam int PROD_W     = GAIN_W + DIFF_W;
  localparam int ACC_W      = 64;
  localparam int FRAC_BITS  = 32;
  localparam int WHOLE_W    = ACC_W - FRAC_BITS;
  localparam int LIM_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST  = GAIN_W'(0);
  localparam logic signed [GAIN_W-1:0] GAIN_INTEG_RST = GAIN_W'(4295);
  localparam logic signed [GAIN_W-1:0] GAIN_DERIV_RST = GAIN_W'(42950);
  localparam logic [LIM_W-1:0]         SLOW_LIMIT_RST = LIM_W'(450);
  localparam logic [LIM_W-1:0]         FAST_LIMIT_RST = LIM_W'(75);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_SLOW_LIMIT = 3'd3,
    REG_FAST_LIMIT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_prop;
    logic signed [GAIN_W-1:0] gain_integ;
    logic signed [GAIN_W-1:0] gain_deriv;
    logic [LIM_W-1:0]         slow_limit;
    logic [LIM_W-1:0]         fast_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic                     clear;
  } item_t;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

// ===== rtl/core/psd_if.sv =====
// psd_if: valid/ready channel interfaces for samples, drive results and
// register writes. Depends on psd_pkg.
interface psd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [psd_pkg::CNT_W-1:0]    pulse_count;
  logic signed [psd_pkg::CNT_W-1:0]    target_count;
  logic                                clear;
  modport source (output valid, pulse_count, target_count, clear, input ready);
  modport sink   (input valid, pulse_count, target_count, clear, output ready);
endinterface

interface psd_out_if;
  logic                        valid;
  logic                        ready;
  logic [psd_pkg::LIM_W-1:0]   drive;
  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

interface psd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [psd_pkg::CFG_IDX_W-1:0]    index;
  logic [psd_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/psd_regs.sv =====
// psd_regs: gain and limit registers written over the configuration channel.
// Depends on psd_pkg and psd_if.
module psd_regs (
  input  logic            clk,
  input  logic            rst_n,
  psd_cfg_if.sink         cfg_ch,
  output psd_pkg::cfg_t   cfg
);
  import psd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_GAIN_PROP:  cfg_nxt.gain_prop  = cfg_ch.data[GAIN_W-1:0];
        REG_GAIN_INTEG: cfg_nxt.gain_integ = cfg_ch.data[GAIN_W-1:0];
        REG_GAIN_DERIV: cfg_nxt.gain_deriv = cfg_ch.data[GAIN_W-1:0];
        REG_SLOW_LIMIT: cfg_nxt.slow_limit = cfg_ch.data[LIM_W-1:0];
        REG_FAST_LIMIT: cfg_nxt.fast_limit = cfg_ch.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop  <= GAIN_PROP_RST;
      cfg_r.gain_integ <= GAIN_INTEG_RST;
      cfg_r.gain_deriv <= GAIN_DERIV_RST;
      cfg_r.slow_limit <= SLOW_LIMIT_RST;
      cfg_r.fast_limit <= FAST_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/core/psd_front.sv =====
// psd_front: accepts samples, forms the error and its change since the last
// sample, and pushes them to the queue. Depends on psd_pkg and psd_if.
module psd_front (
  input  logic             clk,
  input  logic             rst_n,
  psd_in_if.sink           in_ch,
  input  logic             q_full,
  output logic             q_push,
  output psd_pkg::item_t   q_item
);
  import psd_pkg::*;

  logic signed [ERR_W-1:0] last_err_r;
  logic signed [ERR_W-1:0] last_err_nxt;
  logic signed [ERR_W-1:0] err;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  assign err = ERR_W'(in_ch.target_count) - ERR_W'(in_ch.pulse_count);

  always_comb begin
    q_item.err   = err;
    q_item.diff  = DIFF_W'(err) - DIFF_W'(last_err_r);
    q_item.clear = in_ch.clear;
    last_err_nxt = last_err_r;
    // clear keeps the previous error
    if (q_push && !in_ch.clear) begin
      last_err_nxt = err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
    end else begin
      last_err_r <= last_err_nxt;
    end
  end

endmodule

// ===== rtl/core/psd_queue.sv =====
// psd_queue: short FIFO between front and back. Depends on psd_pkg.
module psd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  psd_pkg::item_t   push_item,
  output logic             full,
  input  logic             pop,
  output psd_pkg::item_t   pop_item,
  output logic             empty
);
  import psd_pkg::*;

  item_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_PTR_W:0]   count_r;
  logic [Q_PTR_W:0]   count_nxt;

  assign full     = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/psd_back.sv =====
// psd_back: PID pipeline: gain products, saturating integral, sum, magnitude,
// ceiling to whole units, limit clamp and output register.
// Depends on psd_pkg and psd_if.
module psd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  psd_pkg::cfg_t    cfg,
  input  logic             q_empty,
  input  psd_pkg::item_t   q_item,
  output logic             q_pop,
  psd_out_if.source        out_ch
);
  import psd_pkg::*;

  logic en;

  // stage 1: products
  logic                     v1_r, clr1_r;
  logic signed [PROD_W-1:0] pp1_r, pi1_r, pd1_r;
  // stage 2: P+D, integral
  logic                     v2_r, clr2_r;
  logic signed [ACC_W-1:0]  pd2_r;
  logic signed [ACC_W-1:0]  integ_r, integ_nxt;
  // stage 3: total
  logic                     v3_r, clr3_r;
  logic signed [ACC_W-1:0]  sum3_r;
  // stage 4: magnitude
  logic                     v4_r, clr4_r;
  logic [ACC_W-2:0]         mag4_r, mag_nxt;
  // stage 5: whole units
  logic                     v5_r, clr5_r;
  logic [WHOLE_W-1:0]       whole5_r, whole_nxt;
  // output
  logic                     out_v_r;
  logic [LIM_W-1:0]         drive_r, drive_nxt, slack;

  assign en     = out_ch.ready || !out_v_r;
  assign q_pop  = en && !q_empty;

  assign out_ch.valid = out_v_r;
  assign out_ch.drive = drive_r;

  always_comb begin
    integ_nxt = integ_r;
    if (v1_r) begin
      integ_nxt = clr1_r ? '0 : sat_add(integ_r, ACC_W'(pi1_r));
    end

    if (sum3_r[ACC_W-1]) begin
      mag_nxt = (sum3_r == ACC_MIN) ? ACC_MAX[ACC_W-2:0] : (ACC_W-1)'(-sum3_r);
    end else begin
      mag_nxt = sum3_r[ACC_W-2:0];
    end

    whole_nxt = WHOLE_W'(mag4_r[ACC_W-2:FRAC_BITS]) + WHOLE_W'(|mag4_r[FRAC_BITS-1:0]);

    slack = cfg.slow_limit - whole5_r[LIM_W-1:0];
    if (clr5_r) begin
      drive_nxt = cfg.slow_limit;
    end else if (whole5_r > WHOLE_W'(cfg.slow_limit)) begin
      drive_nxt = cfg.fast_limit;
    end else if (slack < cfg.fast_limit) begin
      drive_nxt = cfg.fast_limit;
    end else begin
      drive_nxt = slack;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      out_v_r <= 1'b0;
      integ_r <= '0;
    end else if (en) begin
      v1_r    <= !q_empty;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      out_v_r <= v5_r;
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clr1_r   <= q_item.clear;
      pp1_r    <= PROD_W'(cfg.gain_prop)  * PROD_W'(q_item.err);
      pi1_r    <= PROD_W'(cfg.gain_integ) * PROD_W'(q_item.err);
      pd1_r    <= PROD_W'(cfg.gain_deriv) * PROD_W'(q_item.diff);
      clr2_r   <= clr1_r;
      pd2_r    <= ACC_W'(pp1_r) + ACC_W'(pd1_r);
      clr3_r   <= clr2_r;
      sum3_r   <= sat_add(pd2_r, integ_r);
      clr4_r   <= clr3_r;
      mag4_r   <= mag_nxt;
      clr5_r   <= clr4_r;
      whole5_r <= whole_nxt;
      drive_r  <= drive_nxt;
    end
  end

endmodule

// ===== rtl/core/pid_speed_drive.sv =====
// pid_speed_drive: top level of the PID speed regulator.
// Depends on psd_pkg, psd_if, psd_regs, psd_front, psd_queue and psd_back.
//
//   channel  | dir | payload                                  | transaction
//   in_ch    | in  | pulse_count, target_count, clear         | one sample
//   out_ch   | out | drive                                    | one drive value
//   cfg_ch   | in  | index (0..4, others ignored), data       | one register write
//
// One sample per cycle sustained while out_ch is not stalled; after acceptance,
// a sample's drive is formed through the queue, the five back stages and the
// output register.
// Synchronous active-low reset clears the integral, last error, queue and valids.
// A stalled output holds the whole back pipeline; the 4-entry queue keeps
// in_ch.ready high until it fills.
module pid_speed_drive (
  input  logic     clk,
  input  logic     rst_n,
  psd_in_if.sink   in_ch,
  psd_out_if.source out_ch,
  psd_cfg_if.sink  cfg_ch
);
  import psd_pkg::*;

  cfg_t  cfg;
  item_t push_item;
  item_t pop_item;
  logic  q_push, q_pop, q_full, q_empty;

  psd_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  psd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (push_item)
  );

  psd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  psd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_item  (pop_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== bench/psd_drive_checker.sv =====
// psd_drive_checker: watches the sample, drive and register-write channels of
// pid_speed_drive, predicts every drive value and compares it in order.
// Depends on psd_pkg and psd_if.
module psd_drive_checker
  import psd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  psd_in_if           in_ch,
  psd_out_if          out_ch,
  psd_cfg_if          cfg_ch,
  output int unsigned errors,
  output int unsigned pending,
  output int unsigned checked
);

  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic [LIM_W-1:0]         slow_lim, fast_lim;
  logic signed [ACC_W-1:0]  integ;
  logic signed [ERR_W-1:0]  prev_err;
  logic [LIM_W-1:0]         drive_q[$];
  int unsigned              n_err, n_chk;

  function automatic logic signed [ACC_W-1:0] clip_add(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    if (s > (ACC_W+1)'(ACC_MAX)) return ACC_MAX;
    if (s < (ACC_W+1)'(ACC_MIN)) return ACC_MIN;
    return s[ACC_W-1:0];
  endfunction

  // Updates the integral and previous error as a side effect.
  function automatic logic [LIM_W-1:0] drive_after(input logic signed [CNT_W-1:0] meas,
                                                   input logic signed [CNT_W-1:0] targ,
                                                   input logic clr);
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] step;
    logic signed [ACC_W-1:0]  p_term, d_term, i_inc, pd_sum, total;
    logic [ACC_W-1:0]         mag, whole;
    if (clr) begin
      integ = '0;
      return slow_lim;
    end
    err    = targ - meas;
    step   = err - prev_err;
    p_term = kp * err;
    d_term = kd * step;
    i_inc  = ki * err;
    integ  = clip_add(integ, i_inc);
    prev_err = err;
    pd_sum = p_term + d_term;
    total  = clip_add(pd_sum, integ);
    if (total < 0) begin
      mag = (total == ACC_MIN) ? ACC_MAX : -total;
    end else begin
      mag = total;
    end
    // whole units, rounded up so that the drive truncates toward zero
    whole = (mag >> FRAC_BITS) + (mag[FRAC_BITS-1:0] != '0);
    if (whole > slow_lim) return fast_lim;
    if (slow_lim - whole[LIM_W-1:0] < fast_lim) return fast_lim;
    return slow_lim - whole[LIM_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [LIM_W-1:0] want;
    if (!rst_n) begin
      kp       = GAIN_PROP_RST;
      ki       = GAIN_INTEG_RST;
      kd       = GAIN_DERIV_RST;
      slow_lim = SLOW_LIMIT_RST;
      fast_lim = FAST_LIMIT_RST;
      integ    = '0;
      prev_err = '0;
      drive_q.delete();
      n_err    = 0;
      n_chk    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (drive_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected drive %0d with nothing pending", out_ch.drive);
        end else begin
          want = drive_q.pop_front();
          n_chk++;
          if (out_ch.drive !== want) begin
            n_err++;
            if (n_err <= 10) begin
              $display("drive mismatch at result %0d: expected %0d, got %0d",
                       n_chk, want, out_ch.drive);
            end
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_GAIN_PROP:  kp       = cfg_ch.data[GAIN_W-1:0];
          REG_GAIN_INTEG: ki       = cfg_ch.data[GAIN_W-1:0];
          REG_GAIN_DERIV: kd       = cfg_ch.data[GAIN_W-1:0];
          REG_SLOW_LIMIT: slow_lim = cfg_ch.data[LIM_W-1:0];
          REG_FAST_LIMIT: fast_lim = cfg_ch.data[LIM_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        drive_q.push_back(drive_after(in_ch.pulse_count, in_ch.target_count, in_ch.clear));
      end
    end
    errors  <= n_err;
    pending <= drive_q.size();
    checked <= n_chk;
  end

endmodule

// ===== bench/tb.sv =====
// tb: drives samples and register writes into pid_speed_drive with bursty
// traffic and a stalling receiver, and gives the verdict.
// Depends on psd_pkg, psd_if, pid_speed_drive and psd_drive_checker.
module tb;
  import psd_pkg::*;

  localparam logic [CFG_IDX_W-1:0]     REG_SPARE_LO = REG_FAST_LIMIT + 3'd1;
  localparam logic [CFG_IDX_W-1:0]     REG_SPARE_HI = '1;
  localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
  localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;
  localparam logic [LIM_W-1:0]         LIM_MAX  = '1;
  localparam logic signed [CNT_W-1:0]  CNT_MAX  = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0]  CNT_MIN  = {1'b1, {(CNT_W-1){1'b0}}};

  typedef enum {MODE_TRACK, MODE_RUN, MODE_NOISE} gen_mode_t;
  typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_SQUARE} stall_mode_t;

  logic clk;
  logic rst_n;

  psd_in_if  in_ch();
  psd_out_if out_ch();
  psd_cfg_if cfg_ch();

  int unsigned n_err, n_pending, n_checked;
  int unsigned n_sent, n_writes, n_settings;
  int          burst_left;
  gen_mode_t   gen_mode;
  int          gen_left, gen_base;
  logic        gen_neg;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_wr_t;
  reg_wr_t wr_q[$];

  pid_speed_drive i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  psd_drive_checker i_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .errors  (n_err),
    .pending (n_pending),
    .checked (n_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: errors");
    $finish;
  end

  // receiver stall pattern
  initial begin
    stall_mode_t smode;
    int          seg_left, period, tick;
    out_ch.ready <= 1'b0;
    seg_left = 0;
    tick     = 0;
    smode    = STALL_NONE;
    period   = 2;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        smode    = stall_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(20, 200);
        period   = $urandom_range(2, 9);
      end
      seg_left--;
      tick++;
      case (smode)
        STALL_NONE:  out_ch.ready <= 1'b1;
        STALL_COIN:  out_ch.ready <= 1'($urandom_range(0, 1));
        STALL_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     out_ch.ready <= ((tick % period) < (period + 1) / 2);
      endcase
    end
  end

  task automatic push_sample(input logic signed [CNT_W-1:0] pc,
                             input logic signed [CNT_W-1:0] tc,
                             input logic clr);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.pulse_count  <= pc;
    in_ch.target_count <= tc;
    in_ch.clear        <= clr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 60);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic random_samples(input int count);
    repeat (count) begin
      logic signed [CNT_W-1:0] pc, tc, tmp;
      logic                    clr;
      int                      off;
      if (gen_left == 0) begin
        off = $urandom_range(0, 9);
        if (off < 4) begin
          gen_mode = MODE_TRACK;
          gen_left = $urandom_range(5, 40);
          gen_base = $urandom_range(0, 4000) - 2000;
        end else if (off < 8) begin
          gen_mode = MODE_RUN;
          gen_left = $urandom_range(10, 320);
          if ($urandom_range(0, 3) == 0) gen_neg = !gen_neg;
        end else begin
          gen_mode = MODE_NOISE;
          gen_left = $urandom_range(1, 12);
        end
      end
      gen_left--;
      case (gen_mode)
        MODE_TRACK: begin
          off = $urandom_range(0, 128) - 64;
          tc  = CNT_W'(gen_base);
          pc  = CNT_W'(gen_base + off);
          clr = ($urandom_range(0, 19) == 0);
        end
        MODE_RUN: begin
          // near-full-scale error of one sign, drives the integral toward its limit
          tc  = CNT_MAX - CNT_W'($urandom_range(0, 255));
          pc  = CNT_MIN + CNT_W'($urandom_range(0, 255));
          clr = 1'b0;
          if (gen_neg) begin
            tmp = tc;
            tc  = pc;
            pc  = tmp;
          end
        end
        default: begin
          pc  = CNT_W'($urandom);
          tc  = CNT_W'($urandom);
          clr = 1'($urandom_range(0, 1));
        end
      endcase
      push_sample(pc, tc, clr);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic queue_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    reg_wr_t w;
    w.idx  = idx;
    w.data = data;
    wr_q.push_back(w);
  endtask

  task automatic spare_write();
    queue_write(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                CFG_DATA_W'({$urandom, $urandom}));
  endtask

  task automatic new_setting(input logic signed [GAIN_W-1:0] kp,
                             input logic signed [GAIN_W-1:0] ki,
                             input logic signed [GAIN_W-1:0] kd,
                             input logic [LIM_W-1:0] slow,
                             input logic [LIM_W-1:0] fast,
                             input logic spare);
    reg_wr_t w;
    drain();
    if (spare) spare_write();
    queue_write(REG_GAIN_PROP, CFG_DATA_W'(kp));
    queue_write(REG_GAIN_INTEG, CFG_DATA_W'(ki));
    queue_write(REG_GAIN_DERIV, CFG_DATA_W'(kd));
    queue_write(REG_SLOW_LIMIT, CFG_DATA_W'(slow));
    queue_write(REG_FAST_LIMIT, CFG_DATA_W'(fast));
    if (spare) spare_write();
    while (wr_q.size() > 0) begin
      w = wr_q.pop_front();
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= w.idx;
      cfg_ch.data  <= w.data;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      n_writes++;
    end
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  function automatic logic signed [GAIN_W-1:0] mild_gain();
    int v;
    v = $urandom_range(0, 1 << 30) - (1 << 29);
    return GAIN_W'(v);
  endfunction

  initial begin
    logic [LIM_W-1:0] slow;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.pulse_count  <= '0;
    in_ch.target_count <= '0;
    in_ch.clear        <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    n_sent     = 0;
    n_writes   = 0;
    n_settings = 1;
    burst_left = 1;
    gen_mode   = MODE_TRACK;
    gen_left   = 0;
    gen_base   = 0;
    gen_neg    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: field extremes, clears, repeated full-scale errors
    push_sample('0, '0, 1'b0);
    push_sample(CNT_MIN, CNT_MAX, 1'b0);
    push_sample(CNT_MIN, CNT_MAX, 1'b0);
    push_sample(CNT_MAX, CNT_MIN, 1'b0);
    push_sample(CNT_MAX, CNT_MIN, 1'b0);
    push_sample('0, '0, 1'b1);
    push_sample(CNT_MAX, CNT_MAX, 1'b0);
    push_sample(CNT_MIN, CNT_MIN, 1'b0);
    push_sample(-16'sd1, '0, 1'b0);
    push_sample('0, -16'sd1, 1'b0);
    push_sample(16'sd100, -16'sd100, 1'b0);
    push_sample(CNT_MAX, CNT_MIN, 1'b1);
    push_sample(CNT_MIN, CNT_MAX, 1'b1);
    push_sample(16'sd1234, 16'sd1234, 1'b0);
    push_sample(CNT_MIN, CNT_MAX, 1'b0);
    push_sample('0, '0, 1'b0);
    random_samples(234);

    // unit gain: integer magnitudes, no rounding up
    new_setting(GAIN_ONE, '0, '0, SLOW_LIMIT_RST, FAST_LIMIT_RST, 1'b0);
    random_samples(200);
    new_setting(GAIN_MAX, GAIN_MAX, GAIN_MIN, LIM_MAX, '0, 1'b0);
    random_samples(450);
    // fast limit above slow limit
    new_setting(GAIN_MIN, GAIN_MIN, GAIN_MAX, '0, LIM_MAX, 1'b0);
    random_samples(450);
    slow = LIM_W'($urandom_range(100, 4000));
    new_setting(mild_gain(), mild_gain() >>> 6, mild_gain(), slow,
                LIM_W'($urandom_range(0, slow)), 1'b0);
    random_samples(150);
    new_setting(GAIN_W'({$urandom, $urandom}), GAIN_W'({$urandom, $urandom}),
                GAIN_W'({$urandom, $urandom}), LIM_W'($urandom), LIM_W'($urandom), 1'b0);
    random_samples(150);
    slow = LIM_W'($urandom_range(1000, 65535));
    new_setting(mild_gain(), mild_gain() >>> 4, mild_gain() >>> 2, slow,
                LIM_W'($urandom_range(0, 500)), 1'b1);
    random_samples(100);

    drain();
    $display("tb: %0d samples sent across %0d register settings (%0d writes)",
             n_sent, n_settings, n_writes);
    $display("tb: %0d drive values compared, with clears, long error runs and limit extremes",
             n_checked);
    if (n_err == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
